[rtl/cht_pkg.sv]
// Shared constants, types and codes for the chained hash table.
package cht_pkg;

    // Table geometry
    localparam int NUM_BUCKETS = 8;
    localparam int CHAIN_DEPTH = 8;
    localparam int MEM_DEPTH   = NUM_BUCKETS * CHAIN_DEPTH;

    // Field widths
    localparam int KEY_W     = 31;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int OUT_BKT_W = 3;
    localparam int OUT_POS_W = 3;
    localparam int SEL_W     = 3;
    localparam int CFG_W     = 4;
    localparam int BKT_W     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int LEN_W     = $clog2(CHAIN_DEPTH + 1);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // APB port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Modulo unit: remainder bits consumed per cycle
    localparam int MOD_BITS = 4;
    localparam int KEY_PAD  = ((KEY_W + MOD_BITS - 1) / MOD_BITS) * MOD_BITS;
    localparam int MOD_CYC  = KEY_PAD / MOD_BITS;
    localparam int MODC_W   = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [BKT_W-1:0]  bkt_t;
    typedef logic [LEN_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CFG_W-1:0]  cfg_t;

    // Register map (word index)
    localparam logic [PADDR_W-3:0] REG_BUCKET_COUNT = '0;
    localparam cfg_t               BUCKET_COUNT_RST = CFG_W'(NUM_BUCKETS);

    // Commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEL_FAIL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LIST_ENTRY = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL_EMPTY = 3'd6;

    // Flat key-store address of slot idx in bucket b
    function automatic addr_t slot_addr(input bkt_t b, input cnt_t idx);
        return ADDR_W'(int'(b) * CHAIN_DEPTH + int'(idx));
    endfunction

endpackage

[rtl/cht_mod.sv]
// Iterative key modulo bucket-count unit, several remainder bits per cycle.
module cht_mod
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cht_pkg::key_t key_in,
    input  cht_pkg::cfg_t nb,
    output logic          done,
    output cht_pkg::bkt_t rem
);
    import cht_pkg::*;

    logic [KEY_PAD-1:0] sh_reg;
    cfg_t               rem_reg;
    cfg_t               rem_next;
    logic [MODC_W-1:0]  cnt_reg;
    logic               run_reg;
    logic               done_reg;

    // Restoring remainder steps, MSB first; remainder stays below nb
    always_comb
    begin
        logic [CFG_W:0] t;
        cfg_t           r;
        r = rem_reg;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            t = {r, sh_reg[KEY_PAD-1-i]};
            if (t >= {1'b0, nb})
            begin
                t = t - {1'b0, nb};
            end
            r = t[CFG_W-1:0];
        end
        rem_next = r;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == MODC_W'(MOD_CYC - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= KEY_PAD'(key_in);
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            sh_reg  <= sh_reg << MOD_BITS;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = BKT_W'(rem_reg);

endmodule

[rtl/chained_hash_table.sv]
// Chained hash table: top level with key store, chain counts and sequencer.
//
// Usage: a request (cmd, key, bucket_sel) is taken when start is high and
// busy is low. cmd selects insert, delete, search or list of one bucket.
// The bucket of a key is key modulo bucket_count (APB register at 0x0,
// 0 acts as 1, values above 8 act as 8); write it only while busy is low.
// Each result appears on status/bucket/position/key_out/last for one cycle
// with result_valid high; last marks the final result of the request.
// Results cannot be held off: the receiver must take them as they come.
// Steps of a request: the key modulo runs first (skipped for list), then
// the chain length is read, then the chain is walked through the
// registered-read key memory at one slot per cycle: search and delete
// scan up to L slots, delete then closes the gap, insert moves L slots
// back and writes the front.
// One request is in flight at a time; busy falls in the cycle the final
// result is shown, and a new request may be taken then (L: chain length).
// Reset clears all chain counts and sets bucket_count to 8; no clearing
// pass is needed, the key memory is only read below a chain's length.
module chained_hash_table
(
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cht_pkg::PADDR_W-1:0]    paddr,
    input  logic [cht_pkg::PDATA_W-1:0]    pwdata,
    output logic [cht_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    // Request
    input  logic                           start,
    output logic                           busy,
    input  logic [cht_pkg::CMD_W-1:0]      cmd,
    input  cht_pkg::key_t                  key,
    input  logic [cht_pkg::SEL_W-1:0]      bucket_sel,
    // Result
    output logic                           result_valid,
    output logic [cht_pkg::STATUS_W-1:0]   status,
    output logic [cht_pkg::OUT_BKT_W-1:0]  bucket,
    output logic [cht_pkg::OUT_POS_W-1:0]  position,
    output cht_pkg::key_t                  key_out,
    output logic                           last
);
    import cht_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SHDN  = 3'd4;
    localparam logic [2:0] S_SHUP  = 3'd5;
    localparam logic [2:0] S_FRONT = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    key_t             key_reg, key_next;
    bkt_t             bucket_reg, bucket_next;
    cnt_t             len_reg, len_next;
    cnt_t             rd_idx_reg, rd_idx_next;
    logic             iss_reg, iss_next;
    logic             rv_reg, rv_next;
    cnt_t             rpos_reg, rpos_next;
    cnt_t             hit_reg, hit_next;
    cfg_t             bcount_reg;
    cfg_t             nb;

    cnt_t             len_tab_reg [NUM_BUCKETS];
    logic             len_we;
    cnt_t             len_wdata;
    cnt_t             cur_len;

    key_t             mem [MEM_DEPTH];
    key_t             mem_q_reg;
    logic             mem_re;
    addr_t            mem_raddr;
    logic             mem_we;
    addr_t            mem_waddr;
    key_t             mem_wdata;

    logic             mod_start;
    logic             mod_done;
    bkt_t             mod_rem;

    logic             emit;
    logic [STATUS_W-1:0] em_status;
    cnt_t             em_pos;
    key_t             em_key;
    logic             em_last;
    logic             last_pos;

    logic                 out_v_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [OUT_BKT_W-1:0] bucket_out_reg;
    logic [OUT_POS_W-1:0] position_reg;
    key_t                 key_out_reg;
    logic                 last_reg;

    logic             cfg_wr;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_BUCKET_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg <= BUCKET_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            bcount_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_BUCKET_COUNT) ? PDATA_W'(bcount_reg) : '0;

    // Effective bucket count
    always_comb
    begin
        if (bcount_reg == '0)
        begin
            nb = CFG_W'(1);
        end
        else if (bcount_reg > CFG_W'(NUM_BUCKETS))
        begin
            nb = CFG_W'(NUM_BUCKETS);
        end
        else
        begin
            nb = bcount_reg;
        end
    end

    // Key modulo unit, loaded straight from the request port on acceptance
    cht_mod u_mod
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .key_in (key),
        .nb     (nb),
        .done   (mod_done),
        .rem    (mod_rem)
    );

    // Key store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    // Chain lengths
    assign cur_len = len_tab_reg[bucket_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                len_tab_reg[i] <= '0;
            end
        end
        else if (len_we)
        begin
            len_tab_reg[bucket_reg] <= len_wdata;
        end
    end

    assign last_pos = (cnt_t'(rpos_reg + 1'b1) == len_reg);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        bucket_next = bucket_reg;
        len_next    = len_reg;
        rd_idx_next = rd_idx_reg;
        iss_next    = iss_reg;
        rv_next     = 1'b0;
        rpos_next   = rpos_reg;
        hit_next    = hit_reg;
        mod_start   = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = slot_addr(bucket_reg, rd_idx_reg);
        mem_we      = 1'b0;
        mem_waddr   = slot_addr(bucket_reg, '0);
        mem_wdata   = mem_q_reg;
        len_we      = 1'b0;
        len_wdata   = len_reg;
        emit        = 1'b0;
        em_status   = ST_FULL_EMPTY;
        em_pos      = '0;
        em_key      = key_reg;
        em_last     = 1'b1;

        // Read issue for the walking states
        if ((state_reg == S_SCAN || state_reg == S_SHDN || state_reg == S_SHUP) && iss_reg)
        begin
            mem_re    = 1'b1;
            rv_next   = 1'b1;
            rpos_next = rd_idx_reg;
            if (state_reg == S_SHUP)
            begin
                rd_idx_next = cnt_t'(rd_idx_reg - 1'b1);
                iss_next    = (rd_idx_reg != '0);
            end
            else
            begin
                rd_idx_next = cnt_t'(rd_idx_reg + 1'b1);
                iss_next    = (cnt_t'(rd_idx_reg + 1'b1) != len_reg);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    key_next = key;
                    if (cmd == CMD_LIST)
                    begin
                        bucket_next = BKT_W'(bucket_sel);
                        state_next  = S_PREP;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    bucket_next = mod_rem;
                    state_next  = S_PREP;
                end
            end

            S_PREP:
            begin
                len_next    = cur_len;
                rd_idx_next = '0;
                iss_next    = 1'b1;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (cur_len >= cnt_t'(CHAIN_DEPTH))
                        begin
                            emit       = 1'b1;
                            em_status  = ST_FULL_EMPTY;
                            state_next = S_IDLE;
                        end
                        else if (cur_len == '0)
                        begin
                            state_next = S_FRONT;
                        end
                        else
                        begin
                            rd_idx_next = cnt_t'(cur_len - 1'b1);
                            state_next  = S_SHUP;
                        end
                    end
                    CMD_DELETE, CMD_SEARCH:
                    begin
                        if (cur_len == '0)
                        begin
                            emit       = 1'b1;
                            em_status  = (cmd_reg == CMD_DELETE) ? ST_DEL_FAIL : ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_LIST:
                    begin
                        if ((CFG_W'(bucket_reg) >= nb) || (cur_len == '0))
                        begin
                            emit       = 1'b1;
                            em_status  = ST_FULL_EMPTY;
                            em_key     = '0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (rv_reg)
                begin
                    if (cmd_reg == CMD_LIST)
                    begin
                        emit      = 1'b1;
                        em_status = ST_LIST_ENTRY;
                        em_pos    = rpos_reg;
                        em_key    = mem_q_reg;
                        em_last   = last_pos;
                        if (last_pos)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else if (mem_q_reg == key_reg)
                    begin
                        hit_next = rpos_reg;
                        if (cmd_reg == CMD_SEARCH)
                        begin
                            emit       = 1'b1;
                            em_status  = ST_FOUND;
                            em_pos     = rpos_reg;
                            state_next = S_IDLE;
                        end
                        else if (last_pos)
                        begin
                            len_we     = 1'b1;
                            len_wdata  = cnt_t'(len_reg - 1'b1);
                            emit       = 1'b1;
                            em_status  = ST_DELETED;
                            em_pos     = rpos_reg;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // restart reads just behind the hit to close the gap
                            rd_idx_next = cnt_t'(rpos_reg + 1'b1);
                            iss_next    = 1'b1;
                            rv_next     = 1'b0;
                            state_next  = S_SHDN;
                        end
                    end
                    else if (last_pos)
                    begin
                        emit       = 1'b1;
                        em_status  = (cmd_reg == CMD_DELETE) ? ST_DEL_FAIL : ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                end
            end

            S_SHDN:
            begin
                if (rv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_addr(bucket_reg, cnt_t'(rpos_reg - 1'b1));
                    if (last_pos)
                    begin
                        len_we     = 1'b1;
                        len_wdata  = cnt_t'(len_reg - 1'b1);
                        emit       = 1'b1;
                        em_status  = ST_DELETED;
                        em_pos     = hit_reg;
                        state_next = S_IDLE;
                    end
                end
            end

            S_SHUP:
            begin
                if (rv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_addr(bucket_reg, cnt_t'(rpos_reg + 1'b1));
                    if (rpos_reg == '0)
                    begin
                        state_next = S_FRONT;
                    end
                end
            end

            S_FRONT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_addr(bucket_reg, '0);
                mem_wdata  = key_reg;
                len_we     = 1'b1;
                len_wdata  = cnt_t'(len_reg + 1'b1);
                emit       = 1'b1;
                em_status  = ST_INSERTED;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Nothing left pending once the request is finished
        if (state_next == S_IDLE)
        begin
            iss_next = 1'b0;
            rv_next  = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iss_reg   <= 1'b0;
            rv_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            rv_reg    <= rv_next;
            out_v_reg <= emit;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        bucket_reg <= bucket_next;
        len_reg    <= len_next;
        rd_idx_reg <= rd_idx_next;
        rpos_reg   <= rpos_next;
        hit_reg    <= hit_next;
        if (emit)
        begin
            status_reg     <= em_status;
            bucket_out_reg <= OUT_BKT_W'(bucket_reg);
            position_reg   <= OUT_POS_W'(em_pos);
            key_out_reg    <= em_key;
            last_reg       <= em_last;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_v_reg;
    assign status       = status_reg;
    assign bucket       = bucket_out_reg;
    assign position     = position_reg;
    assign key_out      = key_out_reg;
    assign last         = last_reg;

endmodule

[rtl/cht_checker.sv]
// Port-level assertions for the chained hash table, bound to the top level.
module cht_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          result_valid,
    input logic [cht_pkg::STATUS_W-1:0]  status,
    input logic                          last
);
    import cht_pkg::*;

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // Only list entries may be followed by further results
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_LIST_ENTRY) |-> last)
        else $error("non-list result without last");

    // More results pending means the block is still busy
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("partial result while idle");

    // Finishing a request always shows its final result
    a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last)
        else $error("request finished without final result");

endmodule

bind chained_hash_table cht_checker u_cht_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .last         (last)
);
